// ===== design/cpud_pkg.sv =====
// Package for the codepage-to-UTF-16 decoder.
// Holds the item types, the kind and status codes and the register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpud_pkg;

    // Width of a table entry and of a source code.
    localparam int unsigned UNIT_BITS = 16;
    localparam int unsigned BYTE_BITS = 8;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SINGLE_BYTE_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_FALLBACK       = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HAS_FALLBACK_TABLE = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MISSING_MARKER     = 2'd3;

    // Reset value of the missing marker (the replacement character).
    localparam logic [UNIT_BITS-1:0] MARKER_RESET = 16'hFFFD;

    // What an input item asks for.
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_WR_MAIN  = 2'd1,
        KIND_WR_FB    = 2'd2,
        KIND_FLUSH    = 2'd3
    } kind_t;

    // Outcome carried with each result item.
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_UNASSIGNED = 2'd1,
        STATUS_TRUNCATED  = 2'd2
    } status_t;

    // Input item.
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_BITS-1:0] data_byte;
        logic [UNIT_BITS-1:0] entry_index;
        logic [UNIT_BITS-1:0] entry_value;
    } req_item_t;

    // Result item.
    typedef struct packed {
        logic [UNIT_BITS-1:0] code_unit;
        status_t              status;
    } rsp_item_t;

    // Lookup stage contents handed from the front end to the resolve stage.
    typedef struct packed {
        logic                 truncate;
        logic [UNIT_BITS-1:0] code;
    } stage_t;

endpackage

`default_nettype wire

// ===== design/codepage_to_unicode_decoder.sv =====
// Codepage-to-UTF-16 decoder, top level. Uses cpud_pkg, cpud_table_ram
// and cpud_resolve.
// A result is held in the lookup stage, then in the result register.
// Throughput: one item per cycle unless rsp_ready stalls, set by the single
// registered port of each table memory: one write or one read per item.
// Reset clears the held lead byte, the configuration registers and the
// pipeline valid bits; the tables are not cleared and must be loaded first.
`timescale 1ns / 1ps
`default_nettype none

module codepage_to_unicode_decoder #(
    parameter int unsigned INDEX_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [cpud_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [cpud_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                req_valid,
    output logic                                     req_ready,
    input  wire cpud_pkg::req_item_t                 req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_ready,
    output cpud_pkg::rsp_item_t                      rsp
);

    localparam int unsigned UB = cpud_pkg::UNIT_BITS;
    localparam int unsigned BB = cpud_pkg::BYTE_BITS;

    // Configuration registers.
    logic          single_byte_mode_reg;
    logic          use_fallback_reg;
    logic          has_fallback_table_reg;
    logic [UB-1:0] missing_marker_reg;

    // Front end state.
    logic [BB-1:0]    lead_reg;
    logic [BB-1:0]    lead_next;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    cpud_pkg::stage_t s1_info_reg;

    logic                  accept;
    logic                  s1_free;
    logic                  s1_take;
    logic                  issue;
    cpud_pkg::stage_t      issue_info;
    logic                  main_we;
    logic                  fb_we;
    logic                  table_re;
    logic [INDEX_BITS-1:0] table_addr;
    logic [UB-1:0]         main_rd;
    logic [UB-1:0]         fb_rd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_byte_mode_reg   <= 1'b0;
            use_fallback_reg       <= 1'b0;
            has_fallback_table_reg <= 1'b0;
            missing_marker_reg     <= cpud_pkg::MARKER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cpud_pkg::CFG_SINGLE_BYTE_MODE:   single_byte_mode_reg   <= cfg_data[0];
                cpud_pkg::CFG_USE_FALLBACK:       use_fallback_reg       <= cfg_data[0];
                cpud_pkg::CFG_HAS_FALLBACK_TABLE: has_fallback_table_reg <= cfg_data[0];
                cpud_pkg::CFG_MISSING_MARKER:     missing_marker_reg     <= cfg_data[UB-1:0];
            endcase
        end
    end

    // A new item enters whenever the lookup stage is empty or moves on.
    assign s1_free   = !s1_valid_reg || s1_take;
    assign req_ready = s1_free;
    assign accept    = req_valid && req_ready;

    // Decode the item: lead byte pairing, table writes and flush.
    always_comb
    begin
        lead_next           = lead_reg;
        issue               = 1'b0;
        issue_info.truncate = 1'b0;
        issue_info.code     = {UB{1'b0}};
        main_we             = 1'b0;
        fb_we               = 1'b0;
        unique case (req.kind)
            cpud_pkg::KIND_DATA:
            begin
                if (single_byte_mode_reg)
                begin
                    issue           = 1'b1;
                    issue_info.code = {{(UB-BB){1'b0}}, req.data_byte};
                end
                else if (lead_reg == {BB{1'b0}})
                begin
                    // A zero byte here is swallowed and leaves nothing held.
                    lead_next = req.data_byte;
                end
                else
                begin
                    issue           = 1'b1;
                    issue_info.code = {lead_reg, req.data_byte};
                    lead_next       = {BB{1'b0}};
                end
            end
            cpud_pkg::KIND_WR_MAIN:
            begin
                main_we = 1'b1;
            end
            cpud_pkg::KIND_WR_FB:
            begin
                fb_we = 1'b1;
            end
            cpud_pkg::KIND_FLUSH:
            begin
                if (lead_reg != {BB{1'b0}})
                begin
                    issue               = 1'b1;
                    issue_info.truncate = 1'b1;
                    issue_info.code     = {{(UB-BB){1'b0}}, lead_reg};
                    lead_next           = {BB{1'b0}};
                end
            end
        endcase
    end

    // Table port address: the entry for writes, the source code for reads.
    assign table_re   = accept && issue && !issue_info.truncate;
    assign table_addr = (main_we || fb_we) ? req.entry_index[INDEX_BITS-1:0]
                                           : issue_info.code[INDEX_BITS-1:0];

    cpud_table_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (UB)
    ) u_main_table (
        .clk   (clk),
        .we    (accept && main_we),
        .re    (table_re),
        .addr  (table_addr),
        .wdata (req.entry_value),
        .rdata (main_rd)
    );

    cpud_table_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (UB)
    ) u_fallback_table (
        .clk   (clk),
        .we    (accept && fb_we),
        .re    (table_re),
        .addr  (table_addr),
        .wdata (req.entry_value),
        .rdata (fb_rd)
    );

    // Lookup stage: only items that give a result enter it.
    assign s1_valid_next = s1_free ? (accept && issue) : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= {BB{1'b0}};
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                lead_reg <= lead_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && issue)
        begin
            s1_info_reg <= issue_info;
        end
    end

    cpud_resolve u_resolve (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid_reg),
        .s1_info        (s1_info_reg),
        .main_rd        (main_rd),
        .fb_rd          (fb_rd),
        .missing_marker (missing_marker_reg),
        .fallback_en    (use_fallback_reg && has_fallback_table_reg),
        .s1_take        (s1_take),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp)
    );

endmodule

`default_nettype wire

// ===== design/cpud_table_ram.sv =====
// Single-port table memory with a registered read port.
// Used for both the main and the fallback code tables; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cpud_table_ram #(
    parameter int unsigned ADDR_BITS = 16,
    parameter int unsigned DATA_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] addr,
    input  wire logic [DATA_BITS-1:0] wdata,
    output logic      [DATA_BITS-1:0] rdata
);

    localparam int unsigned DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/cpud_resolve.sv =====
// Resolve stage: compares the table words with the missing marker and
// fills the result register. Depends on cpud_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpud_resolve (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s1_valid,
    input  wire cpud_pkg::stage_t              s1_info,
    input  wire logic [cpud_pkg::UNIT_BITS-1:0] main_rd,
    input  wire logic [cpud_pkg::UNIT_BITS-1:0] fb_rd,
    input  wire logic [cpud_pkg::UNIT_BITS-1:0] missing_marker,
    input  wire logic                          fallback_en,
    output logic                               s1_take,
    output logic                               rsp_valid,
    input  wire logic                          rsp_ready,
    output cpud_pkg::rsp_item_t                rsp
);

    logic                load_ok;
    logic                main_hit;
    logic                fb_hit;
    cpud_pkg::rsp_item_t result;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    cpud_pkg::rsp_item_t rsp_reg;

    // The result register frees up when empty or when its item is taken.
    assign load_ok = !rsp_valid_reg || rsp_ready;
    assign s1_take = s1_valid && load_ok;

    // Main table first, then the fallback table, then report the raw code.
    assign main_hit = (main_rd != missing_marker);
    assign fb_hit   = fallback_en && (fb_rd != missing_marker);

    always_comb
    begin
        priority if (s1_info.truncate)
        begin
            result.code_unit = s1_info.code;
            result.status    = cpud_pkg::STATUS_TRUNCATED;
        end
        else if (main_hit)
        begin
            result.code_unit = main_rd;
            result.status    = cpud_pkg::STATUS_OK;
        end
        else if (fb_hit)
        begin
            result.code_unit = fb_rd;
            result.status    = cpud_pkg::STATUS_OK;
        end
        else
        begin
            result.code_unit = s1_info.code;
            result.status    = cpud_pkg::STATUS_UNASSIGNED;
        end
    end

    assign rsp_valid_next = load_ok ? s1_valid : rsp_valid_reg;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
